>>> rtl/srsw_pkg.sv
// Shared types, codes and defaults for the selective-repeat send window.
`default_nettype none

package srsw_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam logic [15:0] WindowReset    = 16'd5120;
  localparam logic [15:0] TimeoutReset   = 16'd500;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SENT         = 3'd0,
    KIND_REFUSED      = 3'd1,
    KIND_ACK_DONE     = 3'd2,
    KIND_RETX         = 3'd3,
    KIND_RETX_REFUSED = 3'd4,
    KIND_TICK_DONE    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_CWND    = 2'd0,
    CFG_RWND    = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_e;

  // Which result the datapath builds when the controller emits.
  typedef enum logic [2:0] {
    EMIT_SENT    = 3'd0,
    EMIT_REFUSED = 3'd1,
    EMIT_ACK     = 3'd2,
    EMIT_RETX    = 3'd3,
    EMIT_TICK    = 3'd4
  } emit_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] len;
    logic        acked;
    logic [31:0] tx_time;
  } entry_t;

  typedef struct packed {
    logic  ld_item;
    logic  scan_clr;
    logic  scan_inc;
    logic  time_inc;
    logic  rd_scan;
    logic  rd_oldest;
    logic  wr_store;
    logic  wr_acked;
    logic  wr_time;
    logic  slide;
    logic  emit;
    emit_e emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic refuse;
    logic no_store;
    logic scan_done;
    logic empty;
    logic match;
    logic rd_acked;
    logic timed_out;
    logic can_emit;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/selective_repeat_send_window.sv
// Top level of the selective-repeat sender window.
`default_nettype none

// Sender window for selective-repeat ARQ. Up to WindowEntries outstanding
// packets sit in a circular table held in one RAM with one write and one
// registered read port; every table visit is a read step, then a check step.
// A send is decided and emitted directly, or stored in the table first and then
// emitted. An ack visits entries from the oldest up to the match, or all of
// them when none matches, then frees acked entries from the oldest. A tick
// visits every occupied entry; emits wait for the result register. One item is
// worked at a time; the next input is taken once the final result of the
// current one is in the result register. A tick yields one result per timed
// out entry and a closing tick-done result, flagged by last_result_o. The
// table needs no clearing after reset; only occupied entries are ever read.
// Configuration writes are taken every cycle and must happen while idle.
module selective_repeat_send_window
  import srsw_pkg::*;
#(
  parameter int unsigned WindowEntries = DefaultEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] seq_number_i,
  input  wire logic [15:0] length_bytes_i,
  input  wire logic        no_store_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       result_kind_o,
  output logic [15:0]      out_seq_o,
  output logic [15:0]      out_length_o,
  output logic [15:0]      free_bytes_o,
  output logic             window_overrun_o,
  output logic             last_result_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  srsw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i (command_i),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd)
  );

  srsw_dp #(
    .WindowEntries(WindowEntries)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seq_number_i    (seq_number_i),
    .length_bytes_i  (length_bytes_i),
    .no_store_i      (no_store_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .out_seq_o       (out_seq_o),
    .out_length_o    (out_length_o),
    .free_bytes_o    (free_bytes_o),
    .window_overrun_o(window_overrun_o),
    .last_result_o   (last_result_o)
  );

endmodule

`default_nettype wire

>>> rtl/srsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srsw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/srsw_ctrl.sv
// Sequencer for send, ack search and slide, and tick retransmit scan.
`default_nettype none

module srsw_ctrl
  import srsw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DECIDE    = 11'b000_0000_0010,
    S_SEND_OUT  = 11'b000_0000_0100,
    S_ACK_RD    = 11'b000_0000_1000,
    S_ACK_CHK   = 11'b000_0001_0000,
    S_SLIDE_RD  = 11'b000_0010_0000,
    S_SLIDE_CHK = 11'b000_0100_0000,
    S_ACK_OUT   = 11'b000_1000_0000,
    S_TICK_RD   = 11'b001_0000_0000,
    S_TICK_CHK  = 11'b010_0000_0000,
    S_TICK_OUT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit_sel = EMIT_SENT;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          unique case (command_i)
            CMD_SEND: state_d = S_DECIDE;
            CMD_ACK: begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_ACK_RD;
            end
            CMD_TICK: begin
              cmd_o.scan_clr = 1'b1;
              cmd_o.time_inc = 1'b1;
              state_d        = S_TICK_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DECIDE: begin
        if (status_i.refuse || status_i.no_store) begin
          if (status_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = status_i.refuse ? EMIT_REFUSED : EMIT_SENT;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.wr_store = 1'b1;
          state_d        = S_SEND_OUT;
        end
      end
      S_SEND_OUT: begin
        if (status_i.can_emit) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_SENT;
          state_d        = S_IDLE;
        end
      end
      S_ACK_RD: begin
        if (status_i.scan_done) begin
          state_d = S_SLIDE_RD;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_ACK_CHK;
        end
      end
      S_ACK_CHK: begin
        if (status_i.match) begin
          cmd_o.wr_acked = 1'b1;
          state_d        = S_SLIDE_RD;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_ACK_RD;
        end
      end
      S_SLIDE_RD: begin
        if (status_i.empty) begin
          state_d = S_ACK_OUT;
        end else begin
          cmd_o.rd_oldest = 1'b1;
          state_d         = S_SLIDE_CHK;
        end
      end
      S_SLIDE_CHK: begin
        if (status_i.rd_acked) begin
          cmd_o.slide = 1'b1;
          state_d     = S_SLIDE_RD;
        end else begin
          state_d = S_ACK_OUT;
        end
      end
      S_ACK_OUT: begin
        if (status_i.can_emit) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_ACK;
          state_d        = S_IDLE;
        end
      end
      S_TICK_RD: begin
        if (status_i.scan_done) begin
          state_d = S_TICK_OUT;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        // a timed-out entry waits here until the result register frees up
        if (status_i.timed_out) begin
          if (status_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_RETX;
            cmd_o.wr_time  = 1'b1;
            cmd_o.scan_inc = 1'b1;
            state_d        = S_TICK_RD;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_TICK_RD;
        end
      end
      S_TICK_OUT: begin
        if (status_i.can_emit) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_TICK;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/srsw_dp.sv
// Window datapath: config, counters, entry table, window math, result register.
`default_nettype none

module srsw_dp
  import srsw_pkg::*;
#(
  parameter int unsigned WindowEntries = DefaultEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] seq_number_i,
  input  wire logic [15:0] length_bytes_i,
  input  wire logic        no_store_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       result_kind_o,
  output logic [15:0]      out_seq_o,
  output logic [15:0]      out_length_o,
  output logic [15:0]      free_bytes_o,
  output logic             window_overrun_o,
  output logic             last_result_o
);

  localparam int unsigned IdxW = $clog2(WindowEntries);
  localparam int unsigned CntW = $clog2(WindowEntries + 1);
  localparam int unsigned EntW = $bits(entry_t);

  logic [15:0]     cwnd_q, rwnd_q, timeout_q;
  logic [15:0]     item_seq_q, item_len_q;
  logic            item_nostore_q;
  logic [IdxW-1:0] oldest_q;
  logic [CntW-1:0] count_q, scan_q;
  logic [16:0]     bif_q;
  logic [31:0]     time_q;

  // configuration, taken any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwnd_q    <= WindowReset;
      rwnd_q    <= WindowReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CWND:    cwnd_q    <= cfg_data_i;
        CFG_RWND:    rwnd_q    <= cfg_data_i;
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_seq_q     <= seq_number_i;
      item_len_q     <= length_bytes_i;
      item_nostore_q <= no_store_i;
    end
  end

  // window math
  logic [15:0] limit;
  logic        overrun;
  logic [16:0] free_wide;
  logic [15:0] free_bytes;

  assign limit      = (cwnd_q < rwnd_q) ? cwnd_q : rwnd_q;
  assign overrun    = bif_q > {1'b0, limit};
  assign free_wide  = {1'b0, limit} - bif_q;
  assign free_bytes = overrun ? 16'd0 : free_wide[15:0];

  // slot addressing modulo the table depth
  logic [IdxW:0]   scan_sum, store_sum;
  logic [IdxW-1:0] scan_slot, store_slot, oldest_next;

  assign scan_sum   = {1'b0, oldest_q} + (IdxW + 1)'(scan_q);
  assign store_sum  = {1'b0, oldest_q} + (IdxW + 1)'(count_q);
  assign scan_slot  = (scan_sum >= (IdxW + 1)'(WindowEntries)) ?
                      IdxW'(scan_sum - (IdxW + 1)'(WindowEntries)) : scan_sum[IdxW-1:0];
  assign store_slot = (store_sum >= (IdxW + 1)'(WindowEntries)) ?
                      IdxW'(store_sum - (IdxW + 1)'(WindowEntries)) : store_sum[IdxW-1:0];
  assign oldest_next = (oldest_q == IdxW'(WindowEntries - 1)) ? '0 : oldest_q + 1'b1;

  // entry table
  entry_t          rd_entry, wr_entry;
  logic [EntW-1:0] rdata;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] waddr, raddr;

  assign rd_entry = entry_t'(rdata);
  assign ram_we   = cmd_i.wr_store | cmd_i.wr_acked | cmd_i.wr_time;
  assign ram_re   = cmd_i.rd_scan | cmd_i.rd_oldest;
  assign waddr    = cmd_i.wr_store ? store_slot : scan_slot;
  assign raddr    = cmd_i.rd_oldest ? oldest_q : scan_slot;

  always_comb begin
    wr_entry = rd_entry;
    if (cmd_i.wr_store) begin
      wr_entry.seq     = item_seq_q;
      wr_entry.len     = item_len_q;
      wr_entry.acked   = 1'b0;
      wr_entry.tx_time = time_q;
    end else if (cmd_i.wr_acked) begin
      wr_entry.acked = 1'b1;
    end else begin
      wr_entry.tx_time = time_q;
    end
  end

  srsw_ram #(
    .Width(EntW),
    .Depth(WindowEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // window state
  logic [16:0] bif_sub;
  assign bif_sub = (bif_q > {1'b0, rd_entry.len}) ? bif_q - {1'b0, rd_entry.len} : 17'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
      bif_q    <= '0;
      time_q   <= '0;
      scan_q   <= '0;
    end else begin
      if (cmd_i.time_inc) begin
        time_q <= time_q + 32'd1;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.wr_store) begin
        count_q <= count_q + 1'b1;
        bif_q   <= bif_q + {1'b0, item_len_q};
      end else if (cmd_i.slide) begin
        count_q  <= count_q - 1'b1;
        bif_q    <= bif_sub;
        oldest_q <= oldest_next;
      end
    end
  end

  // status toward the controller
  logic [31:0] age;
  logic        out_valid_q;

  assign age = time_q - rd_entry.tx_time;

  assign status_o.refuse    = ({1'b0, item_len_q} > {1'b0, free_bytes}) ||
                              (!item_nostore_q && (count_q >= CntW'(WindowEntries)));
  assign status_o.no_store  = item_nostore_q;
  assign status_o.scan_done = scan_q == count_q;
  assign status_o.empty     = count_q == '0;
  assign status_o.match     = rd_entry.seq == item_seq_q;
  assign status_o.rd_acked  = rd_entry.acked;
  assign status_o.timed_out = !rd_entry.acked && (age >= {16'd0, timeout_q});
  assign status_o.can_emit  = !out_valid_q || out_ready_i;

  // result register
  kind_e       kind_q, kind_d;
  logic [15:0] oseq_q, oseq_d, olen_q, olen_d, ofree_q;
  logic        olast_q, olast_d, oover_q;

  always_comb begin
    kind_d  = KIND_SENT;
    oseq_d  = item_seq_q;
    olen_d  = item_len_q;
    olast_d = 1'b1;
    unique case (cmd_i.emit_sel)
      EMIT_SENT:    kind_d = KIND_SENT;
      EMIT_REFUSED: kind_d = KIND_REFUSED;
      EMIT_ACK: begin
        kind_d = KIND_ACK_DONE;
        olen_d = '0;
      end
      EMIT_RETX: begin
        kind_d  = (rd_entry.len > free_bytes) ? KIND_RETX_REFUSED : KIND_RETX;
        oseq_d  = rd_entry.seq;
        olen_d  = rd_entry.len;
        olast_d = 1'b0;
      end
      EMIT_TICK: begin
        kind_d = KIND_TICK_DONE;
        oseq_d = '0;
        olen_d = '0;
      end
      default: kind_d = KIND_SENT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= kind_d;
      oseq_q  <= oseq_d;
      olen_q  <= olen_d;
      ofree_q <= free_bytes;
      oover_q <= overrun;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign out_seq_o        = oseq_q;
  assign out_length_o     = olen_q;
  assign free_bytes_o     = ofree_q;
  assign window_overrun_o = oover_q;
  assign last_result_o    = olast_q;

endmodule

`default_nettype wire

>>> rtl/srsw_checker.sv
// Port-level checks for the send window, bound to the top level.
`default_nettype none

module srsw_checker
  import srsw_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  result_kind_o,
  input wire logic [15:0] out_seq_o,
  input wire logic [15:0] out_length_o,
  input wire logic [15:0] free_bytes_o,
  input wire logic        window_overrun_o,
  input wire logic        last_result_o
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(out_seq_o) && $stable(out_length_o) && $stable(free_bytes_o))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o <= KIND_TICK_DONE)
    else $error("undefined result kind");

  a_overrun_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_overrun_o |-> free_bytes_o == 16'd0)
    else $error("free space reported while window overrun");

  // only retransmit results are followed by more results for the same input
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_result_o ==
      !(result_kind_o == KIND_RETX || result_kind_o == KIND_RETX_REFUSED))
    else $error("last flag does not match result kind");

endmodule

bind selective_repeat_send_window srsw_checker u_srsw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_o   (result_kind_o),
  .out_seq_o       (out_seq_o),
  .out_length_o    (out_length_o),
  .free_bytes_o    (free_bytes_o),
  .window_overrun_o(window_overrun_o),
  .last_result_o   (last_result_o)
);

`default_nettype wire

>>> tb/selective_repeat_send_window_test.sv
// Self-checking testbench for the selective-repeat send window, with a window-table scoreboard.
import srsw_pkg::*;

typedef struct packed {
  kind_e       kind;
  logic [15:0] seq;
  logic [15:0] len;
  logic [15:0] free;
  logic        overrun;
  logic        last;
} window_result_t;

// Mirror of the send window; each accepted item queues the results it must produce.
class send_window_scoreboard;
  logic [15:0]    cwnd;
  logic [15:0]    rwnd;
  logic [15:0]    timeout;
  logic [15:0]    slot_seq [DefaultEntries];
  logic [15:0]    slot_len [DefaultEntries];
  bit             slot_acked [DefaultEntries];
  logic [31:0]    slot_time [DefaultEntries];
  int unsigned    head;
  int unsigned    count;
  int unsigned    in_flight;
  logic [31:0]    now;
  window_result_t awaited_results [$];
  int unsigned    errors;

  function new();
    cwnd = WindowReset;
    rwnd = WindowReset;
    timeout = TimeoutReset;
    head = 0;
    count = 0;
    in_flight = 0;
    now = '0;
    errors = 0;
    foreach (slot_seq[i]) begin
      slot_seq[i] = '0;
      slot_len[i] = '0;
      slot_acked[i] = 1'b0;
      slot_time[i] = '0;
    end
  endfunction

  function int unsigned window_limit();
    return (cwnd < rwnd) ? cwnd : rwnd;
  endfunction

  function int unsigned free_space();
    int unsigned limit;
    limit = window_limit();
    return (in_flight > limit) ? 0 : limit - in_flight;
  endfunction

  function void await_result(kind_e kind, logic [15:0] seq, logic [15:0] len, logic last);
    window_result_t r;
    r.kind = kind;
    r.seq = seq;
    r.len = len;
    r.free = 16'(free_space());
    r.overrun = in_flight > window_limit();
    r.last = last;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function void note_item(logic [1:0] cmd, logic [15:0] seq, logic [15:0] len, logic no_store);
    int unsigned s;
    if (cmd == CMD_SEND) begin
      if (len > free_space() || (!no_store && count >= DefaultEntries)) begin
        await_result(KIND_REFUSED, seq, len, 1'b1);
        return;
      end
      if (!no_store) begin
        s = (head + count) % DefaultEntries;
        slot_seq[s] = seq;
        slot_len[s] = len;
        slot_acked[s] = 1'b0;
        slot_time[s] = now;
        count++;
        in_flight += len;
      end
      await_result(KIND_SENT, seq, len, 1'b1);
    end else if (cmd == CMD_ACK) begin
      // only the first match is marked, duplicates further on stay unacked
      for (int unsigned i = 0; i < count; i++) begin
        s = (head + i) % DefaultEntries;
        if (slot_seq[s] == seq) begin
          slot_acked[s] = 1'b1;
          break;
        end
      end
      while (count > 0 && slot_acked[head]) begin
        in_flight = (in_flight > slot_len[head]) ? in_flight - slot_len[head] : 0;
        head = (head + 1) % DefaultEntries;
        count--;
      end
      await_result(KIND_ACK_DONE, seq, 16'h0000, 1'b1);
    end else if (cmd == CMD_TICK) begin
      now = now + 32'd1;
      for (int unsigned i = 0; i < count; i++) begin
        s = (head + i) % DefaultEntries;
        if (!slot_acked[s] && (now - slot_time[s]) >= {16'h0000, timeout}) begin
          await_result((slot_len[s] > free_space()) ? KIND_RETX_REFUSED : KIND_RETX,
                       slot_seq[s], slot_len[s], 1'b0);
          slot_time[s] = now;
        end
      end
      await_result(KIND_TICK_DONE, 16'h0000, 16'h0000, 1'b1);
    end
  endfunction

  function void set_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_CWND:    cwnd = val;
      CFG_RWND:    rwnd = val;
      CFG_TIMEOUT: timeout = val;
      default: ;
    endcase
  endfunction

  // Ack targets: the oldest entry drives the slide, any other one leaves holes.
  function logic [15:0] pick_outstanding();
    if (count == 0) return 16'($urandom);
    if ($urandom_range(99) < 40) return slot_seq[head];
    return slot_seq[(head + $urandom_range(count - 1)) % DefaultEntries];
  endfunction

  function int unsigned pending();
    return awaited_results.size();
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task check_result(logic [2:0] kind, logic [15:0] seq, logic [15:0] len,
                    logic [15:0] free, logic overrun, logic last);
    window_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d seq %0d with nothing awaited", kind, seq));
      return;
    end
    want = awaited_results.pop_front();
    if (kind !== want.kind)
      report_mismatch($sformatf("result_kind %0d, want %0d", kind, want.kind));
    if (seq !== want.seq)
      report_mismatch($sformatf("out_seq %0d, want %0d", seq, want.seq));
    if (len !== want.len)
      report_mismatch($sformatf("out_length %0d, want %0d", len, want.len));
    if (free !== want.free)
      report_mismatch($sformatf("free_bytes %0d, want %0d", free, want.free));
    if (overrun !== want.overrun)
      report_mismatch($sformatf("window_overrun %0b, want %0b", overrun, want.overrun));
    if (last !== want.last)
      report_mismatch($sformatf("last_result %0b, want %0b", last, want.last));
  endtask
endclass

module selective_repeat_send_window_test;

  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned CycleLimit   = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_command = CMD_SEND;
  logic [15:0] in_seq = '0;
  logic [15:0] in_length = '0;
  logic        in_no_store = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_CWND;
  logic [15:0] cfg_data = '0;
  logic        no_idle = 1'b0;
  logic [15:0] next_seq = '0;
  int unsigned cycle_count = 0;

  wire         in_ready;
  wire         out_valid;
  wire [2:0]   result_kind;
  wire [15:0]  out_seq;
  wire [15:0]  out_length;
  wire [15:0]  free_bytes;
  wire         window_overrun;
  wire         last_result;
  wire         cfg_ready;

  send_window_scoreboard sb;

  selective_repeat_send_window DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (in_command),
    .seq_number_i     (in_seq),
    .length_bytes_i   (in_length),
    .no_store_i       (in_no_store),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind),
    .out_seq_o        (out_seq),
    .out_length_o     (out_length),
    .free_bytes_o     (free_bytes),
    .window_overrun_o (window_overrun),
    .last_result_o    (last_result),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(result_kind, out_seq, out_length, free_bytes, window_overrun, last_result);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Valid stays up across back-to-back items; a random gap lowers it in between.
  task automatic offer_item(logic [1:0] cmd, logic [15:0] seq, logic [15:0] len, logic ns);
    int unsigned gap;
    if (!no_idle && $urandom_range(99) < 17) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_seq <= seq;
    in_length <= len;
    in_no_store <= ns;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, seq, len, ns);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  task automatic write_config(logic [15:0] cw, logic [15:0] rw, logic [15:0] to);
    write_register(CFG_CWND, cw);
    write_register(CFG_RWND, rw);
    write_register(CFG_TIMEOUT, to);
    cfg_valid <= 1'b0;
  endtask

  // Drain all awaited results, then give an ignored item time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned items, int unsigned len_max);
    int unsigned done_items;
    int unsigned pick;
    logic [15:0] seq;
    logic [15:0] len;
    done_items = 0;
    next_seq = 16'($urandom);
    while (done_items < items) begin
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(len_max));
      if (pick < 4) begin
        offer_item(CmdUnused, 16'($urandom), len, 1'($urandom_range(1)));
      end else if (pick < 48) begin
        pick = $urandom_range(99);
        if (pick < 84) begin
          seq = next_seq;
          next_seq = next_seq + 16'd1;
        end else if (pick < 92) begin
          seq = 16'($urandom);
        end else begin
          seq = sb.pick_outstanding();
        end
        offer_item(CMD_SEND, seq, len, $urandom_range(99) < 12);
        done_items++;
      end else if (pick < 78) begin
        seq = ($urandom_range(99) < 78) ? sb.pick_outstanding() : 16'($urandom);
        offer_item(CMD_ACK, seq, len, 1'($urandom_range(1)));
        done_items++;
      end else begin
        offer_item(CMD_TICK, 16'($urandom), len, 1'($urandom_range(1)));
        done_items++;
      end
    end
  endtask

  task automatic phase(logic [15:0] cw, logic [15:0] rw, logic [15:0] to,
                       int unsigned len_max, int unsigned items);
    wait_idle();
    write_config(cw, rw, to);
    run_phase(items, len_max);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset windows of 5120 bytes
    offer_item(CMD_SEND, 16'h0000, 16'h0000, 1'b0);
    offer_item(CMD_SEND, 16'hFFFF, 16'hFFFF, 1'b0);   // too long, refused
    offer_item(CMD_SEND, 16'h0001, WindowReset, 1'b0); // window now exactly full
    offer_item(CMD_SEND, 16'h0003, 16'h0000, 1'b1);
    offer_item(CMD_ACK, 16'h0001, 16'h0000, 1'b0);     // newer entry, oldest blocks the slide
    offer_item(CMD_ACK, 16'h8000, 16'hFFFF, 1'b1);     // no match
    offer_item(CMD_ACK, 16'h0001, 16'h0000, 1'b0);     // same entry acked twice
    offer_item(CMD_ACK, 16'h0000, 16'h0000, 1'b0);     // slides to an empty table
    offer_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
    offer_item(CmdUnused, 16'hFFFF, 16'hFFFF, 1'b1);

    // widest windows, zero timeout: fill the table, then retransmit it all at once
    wait_idle();
    write_config(16'hFFFF, 16'hFFFF, 16'h0000);
    for (int i = 0; i < DefaultEntries; i++)
      offer_item(CMD_SEND, 16'(16'hFF00 + i), 16'(1000 + i), 1'b0);
    offer_item(CMD_SEND, 16'h5555, 16'h0000, 1'b0);    // table full
    offer_item(CMD_SEND, 16'hAAAA, 16'h5555, 1'b1);    // unstored send still passes
    offer_item(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
    run_phase(60, 600);

    phase(16'h0000, 16'hFFFF, 16'hFFFF, 40, 45);   // closed window, longest timeout
    no_idle <= 1'b1;
    phase(16'd3000, 16'd1200, 16'd3, 200, 70);
    no_idle <= 1'b0;
    phase(16'hFFFF, 16'd800, 16'd1, 120, 60);
    phase(16'd6000, 16'd9000, 16'd6, 700, 70);
    phase(16'd100, 16'hFFFF, 16'd2, 150, 45);      // shrunk below bytes in flight
    phase(16'hFFFF, 16'hFFFF, 16'd10, 4000, 60);

    wait_idle();
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
